// ===== hw/rtl/msog_pkg.sv =====
// Package for the matrix scan order generator: widths, codes and the structs that
// travel between the configuration block, the step logic and the top level.
// No dependencies.
package msog_pkg;

   localparam int MAX_SIZE = 64;
   localparam int SIZE_W   = 7;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = 13;
   localparam int RUN_W    = 7;
   localparam int DIAG_W   = 7;
   localparam int RING_W   = 6;
   localparam int CALC_W   = 9;

   localparam logic CSR_MATRIX_SIZE = 1'b0;
   localparam logic CSR_SCAN_MODE   = 1'b1;

   typedef enum logic [1:0] {
      MODE_COLUMN,
      MODE_SERPENTINE,
      MODE_ZIGZAG,
      MODE_SPIRAL
   } scan_mode_type;

   typedef enum logic [1:0] {
      SIDE_LEFT,
      SIDE_BOTTOM,
      SIDE_RIGHT,
      SIDE_TOP
   } side_type;

   typedef struct packed {
      logic [SIZE_W-1:0] side_n;
      logic [CNT_W-1:0]  total;
      scan_mode_type     mode;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0]  col;
      logic [CNT_W-1:0]  seq;
      logic [RING_W-1:0] ring;
      side_type          side;
      logic [DIAG_W-1:0] diag;
      logic [RUN_W-1:0]  step;
   } walk_state_type;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [CNT_W-1:0] number;
      logic             last;
   } cell_type;

endpackage

// ===== hw/rtl/matrix_scan_order_generator_top.sv =====
// Top level of the matrix scan order generator: input register, scan position
// state and result register. Depends on msog_pkg, msog_cfg and msog_walk.
//
// Each transfer on the req channel is one tick; req_tdata bit 0 set restarts the
// scan at cell 1, clear advances to the next cell. Each tick yields exactly one
// transfer on the rsp channel with the row, column and sequence number of the
// visited cell, and rsp_tlast marks cell N*N. The tick after the last cell
// starts over at cell 1.
// A tick passes an input register and the step logic into the result register,
// from which its result is offered on the rsp channel. One tick is taken per
// cycle while the receiver takes results; the scan position is updated in the
// same cycle the result register is loaded, which keeps consecutive ticks back
// to back.
// When the receiver stalls, the result register holds and one more tick waits in
// the input register; req_tready drops only when both are full.
// The csr port writes matrix_size (index 0) or scan_mode (index 1);
// any write restarts the scan. Reset sets N = 8, column-major order, cell 1 next.
module matrix_scan_order_generator_top
   import msog_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [0] restart, [7:1] zero
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [5:0] row, [11:6] col, [24:12] cell_number
   output logic              rsp_tlast,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_wdata
);

   cfg_type        cfg;
   walk_state_type st_ff;
   walk_state_type st_in;
   walk_state_type st_next;
   cell_type       visit;
   cell_type       rsp_cell_ff;
   logic           s1_valid_ff;
   logic           s1_valid_in;
   logic           s1_restart_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;
   logic           s1_go;

   msog_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   msog_walk u_walk (
      .cfg     (cfg),
      .cur     (st_ff),
      .restart (s1_restart_ff),
      .visit   (visit),
      .nxt     (st_next)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      s1_go        = s1_valid_ff && out_free;
      req_tready   = !s1_valid_ff || out_free;
      s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      st_in        = st_ff;
      if (csr_we) begin
         st_in = '0;
      end else if (s1_go) begin
         st_in = st_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_restart_ff <= req_tdata[0];
      end
      if (s1_go) begin
         rsp_cell_ff <= visit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_cell_ff.number, rsp_cell_ff.col, rsp_cell_ff.row};
   assign rsp_tlast  = rsp_cell_ff.last;

   a_seq_below_total: assert property (@(posedge clock) disable iff (reset)
      st_ff.seq < cfg.total)
      else $error("scan counter reached the cell count");

   a_clear_on_write: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (st_ff == '0))
      else $error("register write did not restart the scan");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_restart_ff)))
      else $error("waiting tick was lost from the input register");

   a_state_idle: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !csr_we) |=> $stable(st_ff))
      else $error("scan position moved without a tick");

endmodule

// ===== hw/rtl/msog_cfg.sv =====
// Configuration registers of the matrix scan order generator: clamped side length,
// cell count of the whole scan and scan mode. Depends on msog_pkg.
module msog_cfg
   import msog_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_wdata,
   output cfg_type           cfg
);

   logic [SIZE_W-1:0]   side_n_ff;
   logic [SIZE_W-1:0]   side_n_in;
   logic [CNT_W-1:0]    total_ff;
   logic [CNT_W-1:0]    total_in;
   scan_mode_type       mode_ff;
   scan_mode_type       mode_in;
   logic [SIZE_W-1:0]   clamped;
   logic [2*SIZE_W-1:0] square;

   always_comb begin
      if (csr_wdata == '0) begin
         clamped = SIZE_W'(1);
      end else if (csr_wdata > SIZE_W'(MAX_SIZE)) begin
         clamped = SIZE_W'(MAX_SIZE);
      end else begin
         clamped = csr_wdata;
      end
      square    = clamped * clamped;
      side_n_in = side_n_ff;
      total_in  = total_ff;
      mode_in   = mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MATRIX_SIZE: begin
               side_n_in = clamped;
               total_in  = square[CNT_W-1:0];
            end
            CSR_SCAN_MODE: begin
               mode_in = scan_mode_type'(csr_wdata[1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_n_ff <= SIZE_W'(8);
         total_ff  <= CNT_W'(64);
         mode_ff   <= MODE_COLUMN;
      end else begin
         side_n_ff <= side_n_in;
         total_ff  <= total_in;
         mode_ff   <= mode_in;
      end
   end

   assign cfg.side_n = side_n_ff;
   assign cfg.total  = total_ff;
   assign cfg.mode   = mode_ff;

endmodule

// ===== hw/rtl/msog_walk.sv =====
// Step logic of the matrix scan order generator: locates the cell for the current
// scan position and computes the position of the next cell. Depends on msog_pkg.
module msog_walk
   import msog_pkg::*;
(
   input  cfg_type        cfg,
   input  walk_state_type cur,
   input  logic           restart,
   output cell_type       visit,
   output walk_state_type nxt
);

   walk_state_type           st;
   logic [SIZE_W-1:0]        nm1_w;
   logic signed [CALC_W-1:0] nm1_s;
   logic signed [CALC_W-1:0] k_s;
   logic signed [CALC_W-1:0] g_s;
   logic signed [CALC_W-1:0] s_s;
   logic signed [CALC_W-1:0] row_s;
   logic signed [CALC_W-1:0] col_s;
   logic signed [CALC_W-1:0] len_s;
   logic signed [CALC_W-1:0] inc_s;
   logic                     low_half;
   logic [RUN_W-1:0]         step_inc;
   logic [CNT_W-1:0]         number;
   logic                     last;
   logic                     wrap;

   always_comb begin
      st = cur;
      if (restart || (cur.seq >= cfg.total)) begin
         st = '0;
      end
      nm1_w    = cfg.side_n - SIZE_W'(1);
      nm1_s    = signed'({3'b000, nm1_w[IDX_W-1:0]});
      k_s      = signed'({2'b00, st.diag});
      g_s      = signed'({3'b000, st.ring});
      s_s      = signed'({2'b00, st.step});
      low_half = (k_s <= nm1_s);
      row_s    = '0;
      col_s    = '0;
      len_s    = '0;
      case (cfg.mode) inside
         MODE_COLUMN, MODE_SERPENTINE: begin
            col_s = signed'({3'b000, st.col});
            row_s = ((cfg.mode == MODE_SERPENTINE) && st.col[0]) ? (nm1_s - s_s) : s_s;
            len_s = nm1_s + CALC_W'(1);
         end
         MODE_ZIGZAG: begin
            if (!st.diag[0]) begin
               row_s = (low_half ? nm1_s : ((nm1_s <<< 1) - k_s)) - s_s;
               col_s = (low_half ? k_s : nm1_s) - s_s;
            end else begin
               row_s = (low_half ? (nm1_s - k_s) : CALC_W'(0)) + s_s;
               col_s = (low_half ? CALC_W'(0) : (k_s - nm1_s)) + s_s;
            end
            len_s = low_half ? (k_s + CALC_W'(1)) : ((nm1_s <<< 1) + CALC_W'(1) - k_s);
         end
         default: begin
            case (st.side)
               SIDE_LEFT: begin
                  row_s = g_s + s_s;
                  col_s = g_s;
                  len_s = nm1_s + CALC_W'(1) - (g_s <<< 1);
               end
               SIDE_BOTTOM: begin
                  row_s = nm1_s - g_s;
                  col_s = g_s + CALC_W'(1) + s_s;
                  len_s = nm1_s - (g_s <<< 1);
               end
               SIDE_RIGHT: begin
                  row_s = nm1_s - CALC_W'(1) - g_s - s_s;
                  col_s = nm1_s - g_s;
                  len_s = nm1_s - (g_s <<< 1);
               end
               default: begin
                  row_s = g_s;
                  col_s = nm1_s - CALC_W'(1) - g_s - s_s;
                  len_s = nm1_s - CALC_W'(1) - (g_s <<< 1);
               end
            endcase
         end
      endcase
      if (row_s < 0) begin
         row_s = '0;
      end
      if (col_s < 0) begin
         col_s = '0;
      end

      number   = st.seq + CNT_W'(1);
      last     = (number == cfg.total);
      step_inc = st.step + RUN_W'(1);
      inc_s    = signed'({2'b00, step_inc});
      wrap     = (inc_s >= len_s);

      nxt      = st;
      nxt.seq  = number;
      nxt.step = wrap ? '0 : step_inc;
      if (wrap) begin
         case (cfg.mode) inside
            MODE_COLUMN, MODE_SERPENTINE: begin
               nxt.col = st.col + IDX_W'(1);
            end
            MODE_ZIGZAG: begin
               nxt.diag = st.diag + DIAG_W'(1);
            end
            default: begin
               if (st.side == SIDE_TOP) begin
                  nxt.side = SIDE_LEFT;
                  nxt.ring = st.ring + RING_W'(1);
               end else begin
                  nxt.side = side_type'(st.side + 2'd1);
               end
            end
         endcase
      end
      if (last) begin
         nxt = '0;
      end

      visit.row    = row_s[IDX_W-1:0];
      visit.col    = col_s[IDX_W-1:0];
      visit.number = number;
      visit.last   = last;
   end

endmodule

// ===== bench/msog_scan_checker.sv =====
`timescale 1ns / 1ps
// Checker for the matrix scan order generator: follows the csr, req and rsp channels,
// predicts the visited cell of every tick and compares it with the rsp transfers.
// Depends on msog_pkg.
module msog_scan_checker
   import msog_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [7:0]        req_tdata,   // [0] restart, [7:1] zero
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [31:0]       rsp_tdata,   // [5:0] row, [11:6] col, [24:12] cell_number
   input  logic              rsp_tlast,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_wdata,
   output int                mismatch_count,
   output int                cells_pending
);

   logic [SIZE_W-1:0] size_reg;
   scan_mode_type     mode_reg;

   logic [IDX_W-1:0]  pos_col;
   logic [CNT_W-1:0]  pos_seq;
   logic [RING_W-1:0] pos_ring;
   side_type          pos_side;
   logic [DIAG_W-1:0] pos_diag;
   logic [RUN_W-1:0]  pos_step;

   cell_type expected_cells[$];
   int       errors = 0;

   function automatic void clear_walk();
      pos_col  = '0;
      pos_seq  = '0;
      pos_ring = '0;
      pos_side = SIDE_LEFT;
      pos_diag = '0;
      pos_step = '0;
   endfunction

   function automatic int diag_length(int n, int k);
      int d;
      d = n - 1 - k;
      return n - ((d < 0) ? -d : d);
   endfunction

   function automatic int ring_side_length(int n, int g, side_type side);
      int m;
      int len;
      m = n - 2 * g;
      if (side == SIDE_LEFT) begin
         len = m;
      end else if (side == SIDE_TOP) begin
         len = m - 2;
      end else begin
         len = m - 1;
      end
      return (len < 0) ? 0 : len;
   endfunction

   function automatic void step_forward(int n);
      int guard;
      pos_step = pos_step + 1'b1;
      if (mode_reg == MODE_COLUMN || mode_reg == MODE_SERPENTINE) begin
         if (int'(pos_step) >= n) begin
            pos_step = '0;
            pos_col  = pos_col + 1'b1;
         end
      end else if (mode_reg == MODE_ZIGZAG) begin
         if (int'(pos_step) >= diag_length(n, int'(pos_diag))) begin
            pos_step = '0;
            pos_diag = pos_diag + 1'b1;
         end
      end else begin
         for (guard = 0; guard < 8 &&
              int'(pos_step) >= ring_side_length(n, int'(pos_ring), pos_side); guard++) begin
            pos_step = '0;
            if (pos_side == SIDE_TOP) begin
               pos_side = SIDE_LEFT;
               pos_ring = pos_ring + 1'b1;
            end else begin
               pos_side = side_type'(pos_side + 1'b1);
            end
         end
      end
   endfunction

   function automatic cell_type visit_next(logic restart);
      int       n;
      int       total;
      int       r;
      int       c;
      int       s;
      int       k;
      int       d;
      int       g;
      cell_type visit;
      n = int'(size_reg);
      if (n < 1) n = 1;
      if (n > MAX_SIZE) n = MAX_SIZE;
      total = n * n;
      if (restart || int'(pos_seq) >= total) clear_walk();
      s = int'(pos_step);
      case (mode_reg)
         MODE_COLUMN, MODE_SERPENTINE: begin
            c = int'(pos_col);
            r = (mode_reg == MODE_SERPENTINE && pos_col[0]) ? n - 1 - s : s;
         end
         MODE_ZIGZAG: begin
            k = int'(pos_diag);
            d = n - 1 - k;
            if ((diag_length(n, k) % 2) != 0) begin
               r = ((d < 0) ? n - 1 + d : n - 1) - s;
               c = ((d > 0) ? n - 1 - d : n - 1) - s;
            end else begin
               r = ((d > 0) ? d : 0) + s;
               c = ((d < 0) ? -d : 0) + s;
            end
         end
         default: begin
            g = int'(pos_ring);
            case (pos_side)
               SIDE_LEFT: begin
                  r = g + s;
                  c = g;
               end
               SIDE_BOTTOM: begin
                  r = n - 1 - g;
                  c = g + 1 + s;
               end
               SIDE_RIGHT: begin
                  r = n - 2 - g - s;
                  c = n - 1 - g;
               end
               default: begin
                  r = g;
                  c = n - 2 - g - s;
               end
            endcase
         end
      endcase
      if (r < 0) r = 0;
      if (c < 0) c = 0;
      visit.row    = r[IDX_W-1:0];
      visit.col    = c[IDX_W-1:0];
      visit.number = pos_seq + 1'b1;
      visit.last   = (int'(pos_seq) + 1 == total);
      if (visit.last) begin
         clear_walk();
      end else begin
         step_forward(n);
         pos_seq = pos_seq + 1'b1;
      end
      if (mode_reg == MODE_ZIGZAG || mode_reg == MODE_SPIRAL || visit.last) begin
         pos_col = visit.last ? '0 : c[IDX_W-1:0];
      end
      return visit;
   endfunction

   always @(posedge clock) begin
      cell_type want;
      cell_type got;
      if (reset) begin
         size_reg = SIZE_W'(8);
         mode_reg = MODE_COLUMN;
         clear_walk();
         expected_cells.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MATRIX_SIZE) begin
               size_reg = csr_wdata;
            end else begin
               mode_reg = scan_mode_type'(csr_wdata[1:0]);
            end
            clear_walk();
         end
         if (rsp_tvalid && rsp_tready) begin
            got.row    = rsp_tdata[5:0];
            got.col    = rsp_tdata[11:6];
            got.number = rsp_tdata[24:12];
            got.last   = rsp_tlast;
            if (expected_cells.size() == 0) begin
               errors++;
               $display({"%0t: result transfer with no cell expected: ",
                         "row %0d col %0d number %0d last %0d"},
                        $time, got.row, got.col, got.number, got.last);
            end else begin
               want = expected_cells.pop_front();
               if (got.row !== want.row || got.col !== want.col ||
                   got.number !== want.number || got.last !== want.last) begin
                  errors++;
                  $display({"%0t: cell mismatch: expected row %0d col %0d number %0d ",
                            "last %0d, got row %0d col %0d number %0d last %0d"},
                           $time, want.row, want.col, want.number, want.last,
                           got.row, got.col, got.number, got.last);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_cells.push_back(visit_next(req_tdata[0]));
         end
      end
      mismatch_count <= errors;
      cells_pending  <= expected_cells.size();
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the matrix scan order generator: clock, reset, tick and csr stimulus
// with random gaps and stalls, and the final verdict. Depends on msog_pkg,
// matrix_scan_order_generator_top and msog_scan_checker.
module tb_top;
   import msog_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_TICKS = 1800;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;   // [0] restart, [7:1] zero
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;         // [5:0] row, [11:6] col, [24:12] cell_number
   logic              rsp_tlast;
   logic              csr_we     = 1'b0;
   logic              csr_index  = 1'b0;
   logic [SIZE_W-1:0] csr_wdata  = '0;

   int mismatch_count;
   int cells_pending;
   int cycle_count = 0;
   bit gaps_on     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   matrix_scan_order_generator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   msog_scan_checker scan_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .cells_pending  (cells_pending)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_tick(input logic restart);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, restart};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_gap();
      int len;
      len = gaps_on ? pick_gap() : 0;
      if (len > 0) begin
         req_tvalid <= 1'b0;
         repeat (len) @(posedge clock);
      end
   endtask

   // The pending count is registered in the checker, so it is read only after the next edge.
   task automatic wait_all_cells();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cells_pending != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input int value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[SIZE_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic directed_run(input int size, input int mode, input int count,
                               input logic restart_first);
      int i;
      wait_all_cells();
      write_register(CSR_MATRIX_SIZE, size);
      write_register(CSR_SCAN_MODE, mode);
      for (i = 0; i < count; i++) begin
         send_tick(restart_first && i == 0);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int ready_len;
      int stall_len;
      @(posedge clock);
      forever begin
         ready_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                 : $urandom_range(1, 20);
         rsp_tready <= 1'b1;
         repeat (ready_len) @(posedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   initial begin
      int random_sent;
      int roll;
      int size;
      int mode;
      int side;
      int phase_len;
      int i;
      random_sent = 0;
      size = 8;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults, then a restart in the middle of a column.
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      // A write of the mode register restarts a scan that is under way.
      directed_run(8, MODE_SPIRAL, 3, 1'b0);
      // Size zero behaves as a single cell.
      directed_run(0, MODE_COLUMN, 3, 1'b0);
      directed_run(1, MODE_ZIGZAG, 2, 1'b1);
      // Sizes above the maximum are clamped.
      directed_run(127, MODE_SERPENTINE, 3, 1'b0);
      directed_run(2, MODE_ZIGZAG, 5, 1'b0);
      directed_run(2, MODE_SERPENTINE, 5, 1'b0);

      while (random_sent < RANDOM_TICKS) begin
         wait_all_cells();
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            size = $urandom_range(1, 8);
         end else if (roll < 92) begin
            size = $urandom_range(9, 20);
         end else if (roll < 96) begin
            size = $urandom_range(40, 64);
         end else begin
            case ($urandom_range(0, 2))
               0: size = 0;
               1: size = 64;
               default: size = $urandom_range(65, 127);
            endcase
         end
         mode = $urandom_range(0, 3);
         if ($urandom_range(0, 1) == 0) begin
            write_register(CSR_MATRIX_SIZE, size);
            write_register(CSR_SCAN_MODE, mode);
         end else begin
            write_register(CSR_SCAN_MODE, mode);
            write_register(CSR_MATRIX_SIZE, size);
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         side = (size < 1) ? 1 : (size > MAX_SIZE) ? MAX_SIZE : size;
         if (side <= 8) begin
            phase_len = side * side * $urandom_range(1, 3) + $urandom_range(0, 3);
         end else if (side <= 20) begin
            phase_len = side * side + $urandom_range(0, 20);
         end else begin
            phase_len = $urandom_range(100, 300);
         end
         if (phase_len > RANDOM_TICKS - random_sent) begin
            phase_len = RANDOM_TICKS - random_sent;
         end
         for (i = 0; i < phase_len; i++) begin
            send_tick($urandom_range(0, 49) == 0);
            sender_gap();
            if ($urandom_range(0, 199) == 0) begin
               wait_all_cells();
            end
         end
         random_sent += phase_len;
      end

      wait_all_cells();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
